// File: src/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared types, constants and mixing functions of the byte stream hash.
// ----------------------------------------------------------------------------
package sfh_pkg;

	localparam int unsigned QueueDepth = 4;

	// command handed from the front to the back through the queue
	typedef struct packed {
		logic        start;      // first item of a message, load seed
		logic [31:0] seed;
		logic        has_group;  // a full 32-bit group is ready to mix
		logic [31:0] group;
		logic        last;       // message ends, finish and emit
		logic [23:0] tail;       // leftover bytes, first byte low
		logic [1:0]  tail_count;
		logic        nonzero;    // message carried at least one byte
	} sfh_cmd_t;

	// finish stage input
	typedef struct packed {
		logic [31:0] hash;
		logic [23:0] tail;
		logic [1:0]  tail_count;
		logic        nonzero;
	} sfh_fin_t;

	function automatic logic [31:0] sext8(input logic [7:0] b);
		return {{24{b[7]}}, b};
	endfunction

	// one full group into the running hash
	function automatic logic [31:0] mix_group(input logic [31:0] h_in, input logic [31:0] group);
		logic [31:0] h;
		logic [31:0] t;
		h = h_in + {16'h0, group[15:0]};
		t = ({16'h0, group[31:16]} << 11) ^ h;
		h = (h << 16) ^ t;
		h = h + (h >> 11);
		return h;
	endfunction

	// tail rule and avalanche
	function automatic logic [31:0] finish(input logic [31:0] h_in, input logic [23:0] tail,
			input logic [1:0] count);
		logic [31:0] h;
		h = h_in;
		unique case (count)
			2'd3: begin
				h = h + {16'h0, tail[15:0]};
				h = h ^ (h << 16);
				h = h ^ (sext8(tail[23:16]) << 18);
				h = h + (h >> 11);
			end
			2'd2: begin
				h = h + {16'h0, tail[15:0]};
				h = h ^ (h << 11);
				h = h + (h >> 17);
			end
			2'd1: begin
				h = h + sext8(tail[7:0]);
				h = h ^ (h << 10);
				h = h + (h >> 1);
			end
			default: begin
				h = h_in;
			end
		endcase
		h = h ^ (h << 3);
		h = h + (h >> 5);
		h = h ^ (h << 4);
		h = h + (h >> 17);
		h = h ^ (h << 25);
		h = h + (h >> 6);
		return h;
	endfunction

endpackage

// File: src/superfast_byte_stream_hash.sv
// ----------------------------------------------------------------------------
// superfast_byte_stream_hash
// 32-bit SuperFastHash over a byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  input    in         in_valid / in_ready  data_byte, seed, last, no_byte
//  output   out        out_valid/out_ready  hash_value
//
//  One byte is taken every cycle while the queue has room; the group mixer
//  takes one queued command per cycle unless a last one waits for the
//  finish stage, so sustained rate is one item per cycle. A last item is
//  queued, mixed into the finish stage, then finished in the output register.
//  Reset clears the message state, the queue and both valid flags.
//  An output stall fills the finish stage, then the queue; in_ready drops
//  only when the queue is full.
// ----------------------------------------------------------------------------
module superfast_byte_stream_hash #(
	parameter int unsigned QUEUE_DEPTH = sfh_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [31:0] seed,
	input  logic        last,
	input  logic        no_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value
);
	import sfh_pkg::*;

	logic     q_push;
	logic     q_ready;
	sfh_cmd_t q_push_cmd;
	logic     q_valid;
	sfh_cmd_t q_pop_cmd;
	logic     q_pop;

	// byte packing and command issue
	sfh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.seed      (seed),
		.last      (last),
		.no_byte   (no_byte),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_cmd     (q_push_cmd)
	);

	// command queue
	sfh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.push_ready (q_ready),
		.pop_valid  (q_valid),
		.pop_cmd    (q_pop_cmd),
		.pop        (q_pop)
	);

	// mixing, finish and output
	sfh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_pop_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

endmodule

// File: src/sfh_front.sv
// ----------------------------------------------------------------------------
// sfh_front
// Takes bytes, packs them into little-endian groups and issues commands.
// ----------------------------------------------------------------------------
module sfh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic [31:0]       seed,
	input  logic              last,
	input  logic              no_byte,
	input  logic              q_ready,
	output logic              q_push,
	output sfh_pkg::sfh_cmd_t q_cmd
);
	import sfh_pkg::*;

	logic        in_msg_q;
	logic [23:0] pend_q;
	logic [1:0]  cnt_q;
	logic        nz_q;

	logic        xfer;
	logic        start;
	logic [23:0] pend_cur;
	logic [1:0]  cnt_cur;
	logic [23:0] pend_n;
	logic [1:0]  cnt_n;
	logic        nz_n;
	logic        grp_done;

	assign in_ready = q_ready;
	assign xfer     = in_valid && in_ready;
	assign start    = !in_msg_q;

	// byte packing for the current item
	always_comb begin
		pend_cur = start ? 24'h0 : pend_q;
		cnt_cur  = start ? 2'd0 : cnt_q;
		pend_n   = pend_cur;
		cnt_n    = cnt_cur;
		nz_n     = start ? 1'b0 : nz_q;
		grp_done = 1'b0;
		if (!no_byte) begin
			nz_n = 1'b1;
			unique case (cnt_cur)
				2'd0: begin
					pend_n[7:0] = data_byte;
					cnt_n       = 2'd1;
				end
				2'd1: begin
					pend_n[15:8] = data_byte;
					cnt_n        = 2'd2;
				end
				2'd2: begin
					pend_n[23:16] = data_byte;
					cnt_n         = 2'd3;
				end
				2'd3: begin
					grp_done = 1'b1;
					pend_n   = 24'h0;
					cnt_n    = 2'd0;
				end
			endcase
		end
	end

	// command toward the back
	always_comb begin
		q_cmd.start      = start;
		q_cmd.seed       = seed;
		q_cmd.has_group  = grp_done;
		q_cmd.group      = {data_byte, pend_cur};
		q_cmd.last       = last;
		q_cmd.tail       = pend_n;
		q_cmd.tail_count = cnt_n;
		q_cmd.nonzero    = nz_n;
	end

	assign q_push = xfer && (start || grp_done || last);

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			pend_q   <= 24'h0;
			cnt_q    <= 2'd0;
			nz_q     <= 1'b0;
		end else if (xfer) begin
			in_msg_q <= !last;
			pend_q   <= last ? 24'h0 : pend_n;
			cnt_q    <= last ? 2'd0 : cnt_n;
			nz_q     <= last ? 1'b0 : nz_n;
		end
	end

endmodule

// File: src/sfh_queue.sv
// ----------------------------------------------------------------------------
// sfh_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module sfh_queue #(
	parameter int unsigned DEPTH = sfh_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfh_pkg::sfh_cmd_t push_cmd,
	output logic              push_ready,
	output logic              pop_valid,
	output sfh_pkg::sfh_cmd_t pop_cmd,
	input  logic              pop
);
	import sfh_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);
	localparam logic [PW-1:0] PtrOne  = PW'(1);
	localparam logic [CW-1:0] CntOne  = CW'(1);

	sfh_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign push_ready = (cnt_q != FullCnt);
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntOne;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntOne;
			end
		end
	end

endmodule

// File: src/sfh_back.sv
// ----------------------------------------------------------------------------
// sfh_back
// Mixes groups into the running hash, then finishes and holds the result.
// ----------------------------------------------------------------------------
module sfh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  sfh_pkg::sfh_cmd_t q_cmd,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       hash_value
);
	import sfh_pkg::*;

	logic [31:0] rhash_q;
	logic        fin_valid_s1;
	sfh_fin_t    fin_s1;
	logic        out_valid_q;
	logic [31:0] hash_q;

	logic [31:0] h_base;
	logic [31:0] h_mixed;
	logic        out_free;
	logic        s1_free;

	assign out_free = !out_valid_q || out_ready;
	assign s1_free  = !fin_valid_s1 || out_free;
	assign q_pop    = q_valid && (!q_cmd.last || s1_free);

	// group mixing
	always_comb begin
		h_base  = q_cmd.start ? q_cmd.seed : rhash_q;
		h_mixed = q_cmd.has_group ? mix_group(h_base, q_cmd.group) : h_base;
	end

	// running hash and finish stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rhash_q      <= 32'h0;
			fin_valid_s1 <= 1'b0;
		end else begin
			if (q_pop) begin
				rhash_q <= q_cmd.last ? 32'h0 : h_mixed;
			end
			if (s1_free) begin
				fin_valid_s1 <= q_pop && q_cmd.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.last) begin
			fin_s1.hash       <= h_mixed;
			fin_s1.tail       <= q_cmd.tail;
			fin_s1.tail_count <= q_cmd.tail_count;
			fin_s1.nonzero    <= q_cmd.nonzero;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fin_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fin_valid_s1) begin
			hash_q <= fin_s1.nonzero ?
				finish(fin_s1.hash, fin_s1.tail, fin_s1.tail_count) : 32'h0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

// File: src/sfh_checker.sv
// ----------------------------------------------------------------------------
// sfh_checker
// Port-level checks of the byte stream hash, bound to the top level.
// ----------------------------------------------------------------------------
module sfh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] hash_value
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hash_value))
		else $error("result changed while stalled");

	// the queue only fills on a transfer, so ready cannot drop without one
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("input ready dropped with no transfer");

	// no result can be pending right out of reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered right after reset");

endmodule

bind superfast_byte_stream_hash sfh_checker u_sfh_checker (.*);
